/* design/rss_pkg.sv */
// shared constants for the running sample statistics block
`default_nettype none
package rss_pkg;

  localparam int SAMPLE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF  = 32;

  // port payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_FLD_W  = 32;
  localparam int VAR_W      = 64;
  localparam int OUT_DATA_W = 5 * OUT_FLD_W + VAR_W;
  localparam int OUT_USER_W = 1;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

/* design/running_sample_statistics.sv */
// running count, mean, variance, std deviation, min and max over a sample stream
//
//   channel | dir | tdata (lsb first)                                 | tuser
//   in_     | in  | sample                                            | -
//   out_    | out | samples_seen, average, spread_squared, spread,    | ignored
//           |     | smallest, largest                                 |
//
// one item runs through a shift-add / restoring-subtract sequencer:
// mean divide, square, fraction divide, scale multiply, variance divide and a
// two-bit-per-step square root. below two samples the variance phases are
// skipped, and a sample dropped on a full count goes straight to the done
// state. in_tready is high only while the sequencer is idle, so no new sample
// is taken before the last one is through. a finished result waits in the
// output register; the sequencer holds if that register is still occupied.
// reset is synchronous and needs no clearing pass.
`default_nettype none
module running_sample_statistics #(
  parameter int SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = rss_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS  = rss_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rss_pkg::IN_DATA_W-1:0]  in_tdata,   // sample
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // samples_seen, average, spread_squared, spread, smallest, largest
  output logic [rss_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [rss_pkg::OUT_USER_W-1:0]      out_tuser   // ignored
);
  import rss_pkg::*;

  localparam int SW   = SAMPLE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int CB   = COUNT_BITS;
  localparam int AW   = SW + 1;
  localparam int L1   = imax(AW, CB) + 1;
  localparam int SQW  = 2 * AW;
  localparam int L3   = imax(SQW, CB) + 1;
  localparam int PW   = VAR_W + CB;
  localparam int L5   = imax(imax(PW + F, SQW), CB + F) + 2;
  localparam int NW   = imax(imax(L1, L3), L5);
  localparam int RW   = CB + F;
  localparam int ML   = imax(AW, CB);
  localparam int MW   = imax(AW, VAR_W);
  localparam int SCW  = $clog2(NW + 1);
  localparam int XW   = VAR_W + F;
  localparam int XE   = XW + (XW % 2);
  localparam int RB   = XE / 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MEAN, S_SQ, S_PART, S_VMUL, S_VDIV, S_SQRT, S_DONE
  } state_t;

  state_t             state_r;
  logic [CB-1:0]      cnt_r;
  logic [SW-1:0]      mean_r, min_r, max_r;
  logic [VAR_W-1:0]   var_r;
  logic [OUT_FLD_W-1:0] spread_r;
  logic               neg_r, ign_r;
  logic [AW-1:0]      ad_r;
  logic [SQW-1:0]     sq_r;
  logic [NW-1:0]      acc_r;
  logic [RW-1:0]      rem_r, den_r;
  logic [ML-1:0]      mlt_r;
  logic [MW-1:0]      opd_r;
  logic [SCW-1:0]     step_r;
  logic [XE-1:0]      sqx_r;
  logic [RB-1:0]      root_r;
  logic [RB+1:0]      srem_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               out_user_r;

  // datapath steps; the divide and multiply steps are shared between phases
  logic [RW:0]        div_cat;
  logic               div_ge;
  logic [RW-1:0]      div_rem_nxt;
  logic [NW-1:0]      div_acc_nxt, mul_acc_nxt;
  logic [RB+3:0]      sq_cat, sq_trial;
  logic               sq_ge;
  logic [RB+1:0]      srem_nxt;
  logic [RB-1:0]      root_nxt;
  logic [RB+31:0]     root_x;

  always_comb begin
    div_cat     = {rem_r, acc_r[NW-1]};
    div_ge      = div_cat >= {1'b0, den_r};
    div_rem_nxt = div_ge ? RW'(div_cat - {1'b0, den_r}) : div_cat[RW-1:0];
    div_acc_nxt = {acc_r[NW-2:0], div_ge};
    mul_acc_nxt = {acc_r[NW-2:0], 1'b0} + (mlt_r[ML-1] ? NW'(opd_r) : '0);
    sq_cat      = {srem_r, sqx_r[XE-1 -: 2]};
    sq_trial    = (RB+4)'({root_r, 2'b01});
    sq_ge       = sq_cat >= sq_trial;
    srem_nxt    = sq_ge ? (RB+2)'(sq_cat - sq_trial) : (RB+2)'(sq_cat);
    root_nxt    = {root_r[RB-2:0], sq_ge};
    root_x      = (RB+32)'(root_nxt);
  end

  // input decode
  logic [SW-1:0]      x;
  logic [AW-1:0]      d, ad;
  logic [CB-1:0]      n_in;
  logic               full;
  assign x    = SW'(in_tdata);
  assign d    = {x[SW-1], x} - {mean_r[SW-1], mean_r};
  assign ad   = d[AW-1] ? AW'(-d) : d;
  assign n_in = cnt_r + CB'(1);
  assign full = (cnt_r == '1);

  logic [AW-1:0]      q;
  logic [SQW-1:0]     part;
  logic [PW-1:0]      prod;
  logic [VAR_W-1:0]   var_new;
  assign q       = div_acc_nxt[AW-1:0];
  assign part    = div_acc_nxt[SQW-1:0];
  assign prod    = mul_acc_nxt[PW-1:0];
  assign var_new = (|div_acc_nxt[NW-1:VAR_W]) ? '1 : div_acc_nxt[VAR_W-1:0];

  logic last;
  always_comb begin
    case (state_r)
      S_MEAN:  last = (step_r == SCW'(L1 - 1));
      S_SQ:    last = (step_r == SCW'(AW - 1));
      S_PART:  last = (step_r == SCW'(L3 - 1));
      S_VMUL:  last = (step_r == SCW'(CB - 1));
      S_VDIV:  last = (step_r == SCW'(NW - 1));
      S_SQRT:  last = (step_r == SCW'(RB - 1));
      default: last = 1'b0;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mean_r      <= '0;
      var_r       <= '0;
      spread_r    <= '0;
      min_r       <= {1'b0, {(SW-1){1'b1}}};
      max_r       <= {1'b1, {(SW-1){1'b0}}};
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      // in S_DONE the output register is reloaded instead
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ign_r <= full;
            if (full) begin
              state_r <= S_DONE;
            end else begin
              cnt_r  <= n_in;
              neg_r  <= d[AW-1];
              ad_r   <= ad;
              if ($signed(x) < $signed(min_r)) min_r <= x;
              if ($signed(x) > $signed(max_r)) max_r <= x;
              acc_r  <= NW'(L1'(ad) + L1'(n_in >> 1)) << (NW - L1);
              rem_r  <= '0;
              den_r  <= RW'(n_in);
              step_r <= '0;
              state_r <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (last) begin
            mean_r <= neg_r ? mean_r - SW'(q) : mean_r + SW'(q);
            step_r <= '0;
            if (cnt_r < CB'(2)) begin
              var_r   <= '0;
              sqx_r   <= '0;
              srem_r  <= '0;
              root_r  <= '0;
              state_r <= S_SQRT;
            end else begin
              acc_r   <= '0;
              opd_r   <= MW'(ad_r);
              mlt_r   <= ML'(ad_r) << (ML - AW);
              state_r <= S_SQ;
            end
          end else begin
            acc_r  <= div_acc_nxt;
            rem_r  <= div_rem_nxt;
            step_r <= step_r + SCW'(1);
          end
        end
        S_SQ: begin
          if (last) begin
            sq_r    <= mul_acc_nxt[SQW-1:0];
            // ceil(sq / n) as floor((sq + n - 1) / n)
            acc_r   <= NW'(L3'(mul_acc_nxt[SQW-1:0]) + L3'(cnt_r - CB'(1))) << (NW - L3);
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= S_PART;
          end else begin
            acc_r  <= mul_acc_nxt;
            mlt_r  <= {mlt_r[ML-2:0], 1'b0};
            step_r <= step_r + SCW'(1);
          end
        end
        S_PART: begin
          if (last) begin
            sq_r    <= sq_r - part;
            acc_r   <= '0;
            opd_r   <= MW'(var_r);
            mlt_r   <= ML'(cnt_r - CB'(2)) << (ML - CB);
            step_r  <= '0;
            state_r <= S_VMUL;
          end else begin
            acc_r  <= div_acc_nxt;
            rem_r  <= div_rem_nxt;
            step_r <= step_r + SCW'(1);
          end
        end
        S_VMUL: begin
          if (last) begin
            // numerator rounds half up against (n-1) << F
            acc_r   <= (NW'(prod) << F) + NW'(sq_r)
                       + NW'((RW'(cnt_r - CB'(1)) << F) >> 1);
            den_r   <= RW'(cnt_r - CB'(1)) << F;
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= S_VDIV;
          end else begin
            acc_r  <= mul_acc_nxt;
            mlt_r  <= {mlt_r[ML-2:0], 1'b0};
            step_r <= step_r + SCW'(1);
          end
        end
        S_VDIV: begin
          if (last) begin
            var_r   <= var_new;
            sqx_r   <= XE'(var_new) << F;
            srem_r  <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            acc_r  <= div_acc_nxt;
            rem_r  <= div_rem_nxt;
            step_r <= step_r + SCW'(1);
          end
        end
        S_SQRT: begin
          if (last) begin
            spread_r <= (|(root_x >> 32)) ? '1 : root_x[31:0];
            state_r  <= S_DONE;
          end else begin
            sqx_r  <= {sqx_r[XE-3:0], 2'b00};
            srem_r <= srem_nxt;
            root_r <= root_nxt;
            step_r <= step_r + SCW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {OUT_FLD_W'($signed(max_r)), OUT_FLD_W'($signed(min_r)),
                            spread_r, var_r, OUT_FLD_W'($signed(mean_r)),
                            OUT_FLD_W'(cnt_r)};
            out_user_r  <= ign_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer took a second transfer while busy");
  a_ignored_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> cnt_r == '1)
    else $error("ignored flag without a full count");
  a_var_low_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31:1] == 31'd0 |-> out_tdata[127:64] == 64'd0
      && out_tdata[159:128] == 32'd0)
    else $error("nonzero spread below two samples");
`endif

endmodule
`default_nettype wire
